@@ hw/rtl/psum_pkg.sv @@
package psum_pkg;

   localparam int PosW  = 18;
   localparam int ChgW  = 16;
   localparam int AbsW  = 19;
   localparam int SqW   = 38;
   localparam int DenW  = 38;
   localparam int NumW  = 41;
   localparam int QuoW  = 41;
   localparam int PotW  = 40;
   localparam int EntW  = 3 * PosW + ChgW;
   localparam int MaxGrid = 256;

   localparam logic       OP_LOAD  = 1'b0;
   localparam logic       OP_QUERY = 1'b1;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_Z      = 2'd2;
   localparam logic [1:0] REG_COUNT  = 2'd3;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_SAT  = 2'd1;
   localparam logic [1:0] STAT_ZERO = 2'd2;
   localparam logic [1:0] STAT_OOS  = 2'd3;

   typedef struct packed {
      logic valid;
      logic last;
      logic neg;
      logic zero;
   } psum_tag_type;

endpackage

@@ hw/rtl/psum_div.sv @@
module psum_div
   import psum_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  psum_tag_type        in_tag,
   input  logic [NumW-1:0]     in_num,
   input  logic [DenW-1:0]     in_den,
   output psum_tag_type        out_tag,
   output logic [QuoW-1:0]     out_quo
);

   psum_tag_type    tag_ff [QuoW];
   logic [DenW-1:0] rem_ff [QuoW];
   logic [QuoW-1:0] quo_ff [QuoW];
   logic [NumW-1:0] num_ff [QuoW];
   logic [DenW-1:0] den_ff [QuoW];

   for (genvar k = 0; k < QuoW; k++) begin : g_stage
      psum_tag_type    tag_src;
      logic [DenW-1:0] rem_src;
      logic [QuoW-1:0] quo_src;
      logic [NumW-1:0] num_src;
      logic [DenW-1:0] den_src;
      logic [DenW:0]   trial;
      logic            ge;

      if (k == 0) begin : g_first
         assign tag_src = in_tag;
         assign rem_src = '0;
         assign quo_src = '0;
         assign num_src = in_num;
         assign den_src = in_den;
      end else begin : g_next
         assign tag_src = tag_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign num_src = num_ff[k-1];
         assign den_src = den_ff[k-1];
      end

      assign trial = {rem_src, num_src[NumW-1]};
      assign ge    = trial >= {1'b0, den_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else begin
            tag_ff[k] <= tag_src;
         end
         rem_ff[k] <= ge ? DenW'(trial - {1'b0, den_src}) : trial[DenW-1:0];
         quo_ff[k] <= {quo_src[QuoW-2:0], ge};
         num_ff[k] <= {num_src[NumW-2:0], 1'b0};
         den_ff[k] <= den_src;
      end
   end

   assign out_tag = tag_ff[QuoW-1];
   assign out_quo = quo_ff[QuoW-1];

endmodule

@@ hw/rtl/potential_slice_summation.sv @@
// A load transaction writes the particle store directly.
// A query over n summed particles raises rsp_valid after its last term leaves the divider: one
// particle per cycle enters the store read, distance, square and 41-stage divide pipeline.
// A query outside the slice or with no particles goes straight to the done state, which raises rsp_valid.
// The input stalls while a query runs and while its result waits for a full output register.
// Synchronous reset clears control and sets configuration to its defaults; the particle store is not cleared.
module potential_slice_summation
   import psum_pkg::*;
#(
   parameter int MAX_PARTICLES = 1024
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [9:0]          req_slot,
   input  logic [PosW-1:0]     req_pos_x,
   input  logic [PosW-1:0]     req_pos_y,
   input  logic [PosW-1:0]     req_pos_z,
   input  logic signed [ChgW-1:0] req_charge,
   input  logic [7:0]          req_grid_x,
   input  logic [7:0]          req_grid_y,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [PotW-1:0] rsp_potential,
   output logic [7:0]          rsp_point_x,
   output logic [7:0]          rsp_point_y,
   output logic [1:0]          rsp_status,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [10:0]         csr_wdata
);

   localparam int AW   = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int NW   = $clog2(MAX_PARTICLES + 1);
   localparam int AccW = QuoW + 1 + NW;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [8:0]  width_ff, height_ff;
   logic [7:0]  z_ff;
   logic [10:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd64;
         height_ff <= 9'd64;
         z_ff      <= 8'd32;
         count_ff  <= 11'd0;
      end else if (csr_we) begin
         case (csr_index)
            REG_WIDTH:  width_ff  <= csr_wdata[8:0];
            REG_HEIGHT: height_ff <= csr_wdata[8:0];
            REG_Z:      z_ff      <= csr_wdata[7:0];
            REG_COUNT:  count_ff  <= csr_wdata;
            default:    ;
         endcase
      end
   end

   logic [EntW-1:0] mem [MAX_PARTICLES];
   logic [EntW-1:0] rd_data_ff;
   logic [AW-1:0]   rd_addr;

   logic [1:0]      state_ff;
   logic            issuing_ff;
   logic [NW-1:0]   idx_ff, n_ff;
   logic [7:0]      gx_ff, gy_ff;
   logic            oos_ff, skipped_ff;
   logic signed [AccW-1:0] acc_ff;
   logic            rsp_valid_ff;

   logic accept, is_load, is_query, slot_ok, in_slice;
   int unsigned w_lim, h_lim, n_lim;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_load   = accept && (req_opcode == OP_LOAD);
   assign is_query  = accept && (req_opcode == OP_QUERY);
   assign slot_ok   = 32'(req_slot) < MAX_PARTICLES;

   always_comb begin
      w_lim = (32'(width_ff) > MaxGrid) ? MaxGrid : 32'(width_ff);
      h_lim = (32'(height_ff) > MaxGrid) ? MaxGrid : 32'(height_ff);
      n_lim = (32'(count_ff) > MAX_PARTICLES) ? MAX_PARTICLES : 32'(count_ff);
   end

   assign in_slice = (32'(req_grid_x) < w_lim) && (32'(req_grid_y) < h_lim);
   assign rd_addr  = idx_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (is_load && slot_ok) begin
         mem[AW'(req_slot)] <= {req_pos_x, req_pos_y, req_pos_z, req_charge};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Pipeline: read, absolute differences, squares, distance, divide, accumulate.
   psum_tag_type    t1_ff, t2_ff, t3_ff, t4_ff, dv_tag;
   logic [AbsW-1:0] ax_ff, ay_ff, az_ff;
   logic [ChgW-1:0] qm2_ff, qm3_ff;
   logic [SqW-1:0]  sx_ff, sy_ff, sz_ff;
   logic [DenW-1:0] d_ff, d_in;
   logic [ChgW-1:0] qm4_ff;
   logic [QuoW-1:0] dv_quo;

   logic [PosW-1:0]        px, py, pz;
   logic signed [ChgW-1:0] pq;
   logic signed [AbsW:0]   dx, dy, dz;
   logic signed [ChgW:0]   q_ext;

   always_comb begin
      {px, py, pz, pq} = rd_data_ff;
      dx    = $signed({2'b00, gx_ff, 10'b0}) - $signed({2'b00, px});
      dy    = $signed({2'b00, gy_ff, 10'b0}) - $signed({2'b00, py});
      dz    = $signed({2'b00, z_ff, 10'b0}) - $signed({2'b00, pz});
      q_ext = {pq[ChgW-1], pq};
      d_in  = DenW'(sx_ff + sy_ff + sz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         t3_ff <= '0;
         t4_ff <= '0;
      end else begin
         t1_ff <= {(state_ff == ST_RUN) && issuing_ff, idx_ff == n_ff - NW'(1), 1'b0, 1'b0};
         t2_ff <= {t1_ff.valid, t1_ff.last, pq[ChgW-1], t1_ff.zero};
         t3_ff <= t2_ff;
         t4_ff <= {t3_ff.valid, t3_ff.last, t3_ff.neg, d_in == '0};
      end
      ax_ff  <= dx[AbsW] ? AbsW'(-dx) : AbsW'(dx);
      ay_ff  <= dy[AbsW] ? AbsW'(-dy) : AbsW'(dy);
      az_ff  <= dz[AbsW] ? AbsW'(-dz) : AbsW'(dz);
      qm2_ff <= q_ext[ChgW] ? ChgW'(-q_ext) : ChgW'(q_ext);
      sx_ff  <= SqW'(ax_ff * ax_ff);
      sy_ff  <= SqW'(ay_ff * ay_ff);
      sz_ff  <= SqW'(az_ff * az_ff);
      qm3_ff <= qm2_ff;
      d_ff   <= d_in;
      qm4_ff <= qm3_ff;
   end

   psum_div u_div (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (t4_ff),
      .in_num  ({qm4_ff, 25'b0}),
      .in_den  (d_ff),
      .out_tag (dv_tag),
      .out_quo (dv_quo)
   );

   logic signed [AccW-1:0] term;
   logic                   fits;
   logic [AccW-PotW:0]     top_bits;

   assign term     = $signed({{(AccW-QuoW){1'b0}}, dv_quo});
   assign top_bits = acc_ff[AccW-1:PotW-1];
   assign fits     = (&top_bits) || !(|top_bits);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issuing_ff   <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (is_query) begin
                  idx_ff     <= '0;
                  issuing_ff <= 1'b1;
                  if (!in_slice || n_lim == 0) begin
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_RUN: begin
               if (issuing_ff) begin
                  idx_ff <= idx_ff + NW'(1);
                  if (idx_ff == n_ff - NW'(1)) begin
                     issuing_ff <= 1'b0;
                  end
               end
               if (dv_tag.valid && dv_tag.last) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (is_query) begin
         gx_ff      <= req_grid_x;
         gy_ff      <= req_grid_y;
         oos_ff     <= !in_slice;
         n_ff       <= NW'(n_lim);
         acc_ff     <= '0;
         skipped_ff <= 1'b0;
      end else if (state_ff == ST_RUN && dv_tag.valid) begin
         if (dv_tag.zero) begin
            skipped_ff <= 1'b1;
         end else if (dv_tag.neg) begin
            acc_ff <= acc_ff - term;
         end else begin
            acc_ff <= acc_ff + term;
         end
      end
      if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_point_x <= gx_ff;
         rsp_point_y <= gy_ff;
         if (oos_ff) begin
            rsp_potential <= '0;
            rsp_status    <= STAT_OOS;
         end else if (!fits) begin
            rsp_potential <= acc_ff[AccW-1] ? {1'b1, {(PotW-1){1'b0}}}
                                            : {1'b0, {(PotW-1){1'b1}}};
            rsp_status    <= STAT_SAT;
         end else begin
            rsp_potential <= acc_ff[PotW-1:0];
            rsp_status    <= skipped_ff ? STAT_ZERO : STAT_OK;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
